// ===== src/ppa_pkg.sv =====
// shared types and constants for the page pool first-fit allocator
// no dependencies; every other file imports this package
package ppa_pkg;

  localparam int unsigned MAX_PAGES = 16;
  localparam int unsigned PAGE_SIZE = 4096;
  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned IDX_W     = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int unsigned CNT_W     = $clog2(MAX_PAGES + 1);
  localparam int unsigned PIDX_W    = 4;

  localparam logic [SIZE_W-1:0] PAGE_SIZE_C = SIZE_W'(PAGE_SIZE);

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } ppa_state_e;

  // request travelling down the row of page cells, picking up its answer
  typedef struct packed {
    logic              valid;
    logic [SIZE_W-1:0] size;
    logic              found;
    logic [IDX_W-1:0]  idx;
    logic [SIZE_W-1:0] offset;
    logic              fresh;
  } ppa_tok_t;

endpackage

// ===== src/ppa_if.sv =====
// valid/ready channels for requests and results of the page allocator
// depends on ppa_pkg for field widths
interface ppa_req_if import ppa_pkg::*;;
  logic              valid;
  logic              ready;
  logic              func;
  logic [SIZE_W-1:0] request_size;

  modport source (output valid, output func, output request_size, input ready);
  modport sink   (input valid, input func, input request_size, output ready);
endinterface

interface ppa_rsp_if import ppa_pkg::*;;
  logic              valid;
  logic              ready;
  logic              granted;
  logic [PIDX_W-1:0] page_index;
  logic [SIZE_W-1:0] offset;
  logic              new_page;
  logic              table_full;

  modport source (output valid, output granted, output page_index, output offset,
                  output new_page, output table_full, input ready);
  modport sink   (input valid, input granted, input page_index, input offset,
                  input new_page, input table_full, output ready);
endinterface

// ===== src/ppa_cell.sv =====
// one page entry: capacity and bump offset, plus one stage of the search token
// depends on ppa_pkg
module ppa_cell import ppa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic             in_use_i,
  input  logic [IDX_W-1:0] cell_idx_i,
  input  ppa_tok_t         tok_i,
  output ppa_tok_t         tok_o
);

  logic [SIZE_W-1:0] cap_q, cap_d;
  logic [SIZE_W-1:0] used_q, used_d;
  ppa_tok_t          tok_q, tok_d;
  logic [SIZE_W-1:0] room;
  logic              fits;
  logic              claim;

  always_comb begin
    room  = (cap_q >= used_q) ? (cap_q - used_q) : '0;
    fits  = in_use_i && (tok_i.size <= PAGE_SIZE_C) && (room >= tok_i.size);
    // pages are used as a prefix, so the first free cell is the next page
    claim = !in_use_i;

    cap_d  = cap_q;
    used_d = used_q;
    tok_d  = tok_i;

    if (clear_i) begin
      cap_d  = PAGE_SIZE_C;
      used_d = '0;
    end else if (tok_i.valid && !tok_i.found) begin
      if (fits) begin
        used_d       = used_q + tok_i.size;
        tok_d.found  = 1'b1;
        tok_d.idx    = cell_idx_i;
        tok_d.offset = used_q;
        tok_d.fresh  = 1'b0;
      end else if (claim) begin
        cap_d        = (tok_i.size > PAGE_SIZE_C) ? tok_i.size : PAGE_SIZE_C;
        used_d       = tok_i.size;
        tok_d.found  = 1'b1;
        tok_d.idx    = cell_idx_i;
        tok_d.offset = '0;
        tok_d.fresh  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= PAGE_SIZE_C;
      used_q <= '0;
      tok_q  <= '0;
    end else begin
      cap_q  <= cap_d;
      used_q <= used_d;
      tok_q  <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== src/page_pool_first_fit_allocator_unit.sv =====
// channel  dir  fields                                              accepted when
// req_i    in   func, request_size                                  valid && ready
// rsp_o    out  granted, page_index, offset, new_page, table_full   valid && ready
//
// an allocate item walks the row of MAX_PAGES page cells, one cell per cycle,
// and its result is registered from the token that leaves the last cell
// a release item clears the row and its result shows the next cycle
// one item at a time; a new item is taken once the result register is free or
// being emptied, so a stalled result holds the input off
// reset leaves one empty page of PAGE_SIZE bytes
// depends on ppa_pkg, ppa_if and ppa_cell
module page_pool_first_fit_allocator_unit import ppa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ppa_req_if.sink   req_i,
  ppa_rsp_if.source rsp_o
);

  ppa_state_e        state_q, state_d;
  logic [CNT_W-1:0]  pages_q;
  ppa_tok_t          tok [MAX_PAGES+1];
  logic [MAX_PAGES-1:0] in_use;
  logic              accept;
  logic              clear;
  ppa_tok_t          tail;

  logic              rsp_valid_q;
  logic              granted_q;
  logic [PIDX_W-1:0] page_index_q;
  logic [SIZE_W-1:0] offset_q;
  logic              new_page_q;
  logic              table_full_q;

  assign req_i.ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;
  assign clear       = accept && (req_i.func == FUNC_RELEASE);
  assign tail        = tok[MAX_PAGES];

  always_comb begin
    tok[0].valid  = accept && (req_i.func == FUNC_ALLOC);
    tok[0].size   = req_i.request_size;
    tok[0].found  = 1'b0;
    tok[0].idx    = '0;
    tok[0].offset = '0;
    tok[0].fresh  = 1'b0;
  end

  for (genvar g = 0; g < MAX_PAGES; g++) begin : g_cell
    assign in_use[g] = CNT_W'(g) < pages_q;

    ppa_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .clear_i    (clear),
      .in_use_i   (in_use[g]),
      .cell_idx_i (IDX_W'(g)),
      .tok_i      (tok[g]),
      .tok_o      (tok[g+1])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (req_i.func == FUNC_ALLOC)) state_d = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (tail.valid) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pages_q     <= CNT_W'(1);
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clear) begin
        pages_q <= CNT_W'(1);
      end else if (tail.valid && tail.found && tail.fresh) begin
        pages_q <= CNT_W'(tail.idx) + CNT_W'(1);
      end
      if (clear || tail.valid) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clear) begin
      granted_q    <= 1'b1;
      page_index_q <= '0;
      offset_q     <= '0;
      new_page_q   <= 1'b0;
      table_full_q <= 1'b0;
    end else if (tail.valid) begin
      // no cell took the item: table full, pool left as it was
      granted_q    <= tail.found;
      page_index_q <= tail.found ? PIDX_W'(tail.idx) : '0;
      offset_q     <= tail.found ? tail.offset : '0;
      new_page_q   <= tail.found && tail.fresh;
      table_full_q <= !tail.found;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.granted    = granted_q;
  assign rsp_o.page_index = page_index_q;
  assign rsp_o.offset     = offset_q;
  assign rsp_o.new_page   = new_page_q;
  assign rsp_o.table_full = table_full_q;

endmodule

// ===== src/ppa_checker.sv =====
// port-level checks on the page pool first-fit allocator, bound to the top level
// depends on ppa_pkg
module ppa_checker import ppa_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic              req_func_i,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input logic              rsp_granted_i,
  input logic [PIDX_W-1:0] rsp_page_index_i,
  input logic [SIZE_W-1:0] rsp_offset_i,
  input logic              rsp_new_page_i,
  input logic              rsp_table_full_i
);

  // a release answers on the very next cycle with an empty grant
  a_release_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && (req_func_i == FUNC_RELEASE) |=>
      rsp_valid_i && rsp_granted_i && !rsp_new_page_i && !rsp_table_full_i
      && (rsp_page_index_i == '0) && (rsp_offset_i == '0))
    else $error("release item gave wrong result");

  a_full_not_granted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_table_full_i |->
      !rsp_granted_i && !rsp_new_page_i && (rsp_page_index_i == '0)
      && (rsp_offset_i == '0))
    else $error("table full result carries a grant");

  // a fresh page is always handed out from its start
  a_new_page_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_new_page_i |-> rsp_granted_i && (rsp_offset_i == '0))
    else $error("new page not granted at offset zero");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_offset_i)
      && $stable(rsp_page_index_i) && $stable(rsp_granted_i))
    else $error("stalled result changed");

endmodule

bind page_pool_first_fit_allocator_unit ppa_checker u_ppa_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .req_func_i       (req_i.func),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_granted_i    (rsp_o.granted),
  .rsp_page_index_i (rsp_o.page_index),
  .rsp_offset_i     (rsp_o.offset),
  .rsp_new_page_i   (rsp_o.new_page),
  .rsp_table_full_i (rsp_o.table_full)
);
